// ----- rtl/lrc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrc_pkg
// Shared widths, reset values, register indexes and pipeline flag types of
// the line to rectangle clipper.
// ----------------------------------------------------------------------------
package lrc_pkg;

    localparam int FIELD_W          = 19;
    localparam int DIFF_W           = FIELD_W + 1;
    localparam int REG_W            = 13;
    localparam int FRAC_BITS_DEF    = 4;
    localparam int TDATA_W          = 80;

    localparam logic [REG_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [REG_W-1:0] HEIGHT_RESET = 13'd480;

    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_index_t;

    // Line class that travels alongside the crossings through the dividers.
    typedef struct packed {
        logic ex_zero;
        logic dy_zero;
        logic same_sign;
    } line_flags_t;

endpackage

// ----- rtl/lrc_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrc_divider
// Pipelined signed divider, one quotient bit per stage, truncating toward
// zero. Accepts a new request every cycle while en is high.
// ----------------------------------------------------------------------------
module lrc_divider #(
    parameter int NUM_W = 41,
    parameter int DEN_W = 20
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [NUM_W-1:0] num,
    input  logic signed [DEN_W-1:0] den,
    output logic signed [NUM_W-1:0] quo
);

    logic [NUM_W-1:0] n_reg   [0:NUM_W];
    logic [DEN_W-1:0] d_reg   [0:NUM_W];
    logic [DEN_W-1:0] r_reg   [0:NUM_W];
    logic [NUM_W-1:0] q_reg   [0:NUM_W];
    logic             neg_reg [0:NUM_W];
    logic [NUM_W-1:0] quo_reg;

    // Magnitudes and quotient sign.
    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg[0]   <= num[NUM_W-1] ? (NUM_W'(0) - num) : num;
            d_reg[0]   <= den[DEN_W-1] ? (DEN_W'(0) - den) : den;
            r_reg[0]   <= '0;
            q_reg[0]   <= '0;
            neg_reg[0] <= num[NUM_W-1] ^ den[DEN_W-1];
        end
    end

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [DEN_W:0] shifted;
        logic [DEN_W:0] diff;
        logic           qbit;

        assign shifted = {r_reg[k], n_reg[k][NUM_W-1]};
        assign diff    = shifted - {1'b0, d_reg[k]};
        assign qbit    = (shifted >= {1'b0, d_reg[k]});

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[k+1]   <= qbit ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
                n_reg[k+1]   <= {n_reg[k][NUM_W-2:0], 1'b0};
                q_reg[k+1]   <= {q_reg[k][NUM_W-2:0], qbit};
                d_reg[k+1]   <= d_reg[k];
                neg_reg[k+1] <= neg_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quo_reg <= neg_reg[NUM_W] ? (NUM_W'(0) - q_reg[NUM_W]) : q_reg[NUM_W];
        end
    end

    assign quo = $signed(quo_reg);

endmodule

// ----- rtl/line_rectangle_clip_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_rectangle_clip_core
// Clips the infinite line through two fixed point points against the edges
// of a configurable image rectangle and returns two endpoints.
// ----------------------------------------------------------------------------
// Pipeline: capture, direction, products, numerators, the bit-per-stage
// dividers and the output register, in that order.
// Throughput: one request per cycle; the whole pipeline holds while a result
// waits on m_tready, so nothing is lost or repeated.
// Reset: aresetn clears all valid bits and loads width 640 and height 480.
// ----------------------------------------------------------------------------
module line_rectangle_clip_core #(
    parameter int COORD_FRAC_BITS = lrc_pkg::FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Configuration writes.
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [lrc_pkg::REG_W-1:0]   cfg_wdata,
    // Request stream.
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // first_x, first_y, second_x, second_y from bit 0 up, zero padded.
    input  logic [lrc_pkg::TDATA_W-1:0] s_tdata,
    // Result stream.
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // start_x, start_y, end_x, end_y from bit 0 up, zero padded.
    output logic [lrc_pkg::TDATA_W-1:0] m_tdata
);

    localparam int FW     = lrc_pkg::FIELD_W;
    localparam int DW     = lrc_pkg::DIFF_W;
    localparam int RW     = lrc_pkg::REG_W;
    // Scaled edge positions.
    localparam int WQ_W   = RW + COORD_FRAC_BITS;
    // Point products and the line constant c = dy*ax + ex*ay.
    localparam int PA_W   = DW + FW;
    localparam int C_W    = PA_W + 1;
    // Edge products dy*Wq and ex*Hq.
    localparam int PE_W   = DW + WQ_W + 1;
    localparam int NUM_W  = ((C_W > PE_W) ? C_W : PE_W) + 1;
    localparam int DIV_LAT = NUM_W + 2;

    localparam logic signed [NUM_W-1:0] SENT = NUM_W'(-(2 ** COORD_FRAC_BITS));
    localparam logic signed [NUM_W-1:0] F_MAX = NUM_W'((2 ** (FW - 1)) - 1);
    localparam logic signed [NUM_W-1:0] F_MIN = NUM_W'(-(2 ** (FW - 1)));

    function automatic logic [FW-1:0] sat_field(input logic signed [NUM_W-1:0] v);
        logic [FW-1:0] r;
        if (v > F_MAX) begin
            r = F_MAX[FW-1:0];
        end else if (v < F_MIN) begin
            r = F_MIN[FW-1:0];
        end else begin
            r = v[FW-1:0];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers, changed by the user only while the block is idle (not enforced).
    // ------------------------------------------------------------------
    logic [RW-1:0] width_reg;
    logic [RW-1:0] height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= lrc_pkg::WIDTH_RESET;
            height_reg <= lrc_pkg::HEIGHT_RESET;
        end else if (cfg_we) begin
            unique case (lrc_pkg::reg_index_t'(cfg_index))
                lrc_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_wdata;
                lrc_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic [WQ_W-1:0] wq;
    logic [WQ_W-1:0] hq;
    assign wq = WQ_W'(width_reg) << COORD_FRAC_BITS;
    assign hq = WQ_W'(height_reg) << COORD_FRAC_BITS;

    // The whole pipeline advances together whenever the output register can
    // take a new result.
    logic en;
    logic m_tvalid_reg;
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // ------------------------------------------------------------------
    // Stage 1: capture the request.
    // ------------------------------------------------------------------
    logic                 v1_reg;
    logic signed [FW-1:0] ax1_reg, ay1_reg, bx1_reg, by1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ax1_reg <= s_tdata[FW-1:0];
            ay1_reg <= s_tdata[2*FW-1:FW];
            bx1_reg <= s_tdata[3*FW-1:2*FW];
            by1_reg <= s_tdata[4*FW-1:3*FW];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: direction, dy = By - Ay and ex = Ax - Bx.
    // ------------------------------------------------------------------
    logic                 v2_reg;
    logic signed [DW-1:0] dy2_reg, ex2_reg;
    logic signed [FW-1:0] ax2_reg, ay2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dy2_reg <= DW'(by1_reg) - DW'(ay1_reg);
            ex2_reg <= DW'(ax1_reg) - DW'(bx1_reg);
            ax2_reg <= ax1_reg;
            ay2_reg <= ay1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: the four products.
    // ------------------------------------------------------------------
    logic                   v3_reg;
    logic signed [PA_W-1:0] p_dyax3_reg, p_exay3_reg;
    logic signed [PE_W-1:0] p_dywq3_reg, p_exhq3_reg;
    logic signed [DW-1:0]   dy3_reg, ex3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_dyax3_reg <= PA_W'(dy2_reg) * PA_W'(ax2_reg);
            p_exay3_reg <= PA_W'(ex2_reg) * PA_W'(ay2_reg);
            p_dywq3_reg <= PE_W'(dy2_reg) * PE_W'($signed({1'b0, wq}));
            p_exhq3_reg <= PE_W'(ex2_reg) * PE_W'($signed({1'b0, hq}));
            dy3_reg     <= dy2_reg;
            ex3_reg     <= ex2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: divider numerators and the line class.
    // ------------------------------------------------------------------
    logic                    v4_reg;
    logic signed [C_W-1:0]   c_sum;
    logic signed [NUM_W-1:0] c4_reg, nr4_reg, nb4_reg;
    logic signed [DW-1:0]    dy4_reg, ex4_reg;
    lrc_pkg::line_flags_t    flags_next;
    lrc_pkg::line_flags_t    flags4_reg;

    assign c_sum = C_W'(p_dyax3_reg) + C_W'(p_exay3_reg);

    always_comb begin
        flags_next.ex_zero   = (ex3_reg == '0);
        flags_next.dy_zero   = (dy3_reg == '0);
        flags_next.same_sign = ((dy3_reg > 0) == (ex3_reg > 0));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c4_reg     <= NUM_W'(c_sum);
            nr4_reg    <= NUM_W'(c_sum) - NUM_W'(p_dywq3_reg);
            nb4_reg    <= NUM_W'(c_sum) - NUM_W'(p_exhq3_reg);
            dy4_reg    <= dy3_reg;
            ex4_reg    <= ex3_reg;
            flags4_reg <= flags_next;
        end
    end

    // ------------------------------------------------------------------
    // Dividers: left.y, right.y over ex and top.x, bottom.x over dy.
    // ------------------------------------------------------------------
    logic signed [NUM_W-1:0] q_left, q_right, q_top, q_bottom;

    lrc_divider #(.NUM_W(NUM_W), .DEN_W(DW)) u_div_left (
        .aclk(aclk), .en(en), .num(c4_reg),  .den(ex4_reg), .quo(q_left)
    );
    lrc_divider #(.NUM_W(NUM_W), .DEN_W(DW)) u_div_right (
        .aclk(aclk), .en(en), .num(nr4_reg), .den(ex4_reg), .quo(q_right)
    );
    lrc_divider #(.NUM_W(NUM_W), .DEN_W(DW)) u_div_top (
        .aclk(aclk), .en(en), .num(c4_reg),  .den(dy4_reg), .quo(q_top)
    );
    lrc_divider #(.NUM_W(NUM_W), .DEN_W(DW)) u_div_bottom (
        .aclk(aclk), .en(en), .num(nb4_reg), .den(dy4_reg), .quo(q_bottom)
    );

    // Valid bits and line class follow the dividers stage for stage.
    logic                 vline_reg [0:DIV_LAT-1];
    lrc_pkg::line_flags_t fline_reg [0:DIV_LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DIV_LAT; i++) begin
                vline_reg[i] <= 1'b0;
            end
        end else if (en) begin
            vline_reg[0] <= v4_reg;
            for (int i = 1; i < DIV_LAT; i++) begin
                vline_reg[i] <= vline_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fline_reg[0] <= flags4_reg;
            for (int i = 1; i < DIV_LAT; i++) begin
                fline_reg[i] <= fline_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Final stage: edge points, endpoint choice and saturation.
    // A parallel edge, or a zero sized image, turns the pair of edge points
    // into the sentinel; the sentinel then also takes part in the compares.
    // ------------------------------------------------------------------
    lrc_pkg::line_flags_t    fl;
    logic                    lr_ok, tb_ok;
    logic signed [NUM_W-1:0] lx, ly, rx, ry, tx, ty, bx, by;
    logic signed [NUM_W-1:0] sx, sy, ex_o, ey_o;

    assign fl    = fline_reg[DIV_LAT-1];
    assign lr_ok = !fl.ex_zero && (height_reg != '0);
    assign tb_ok = !fl.dy_zero && (width_reg != '0);

    always_comb begin
        lx = lr_ok ? '0 : SENT;
        ly = lr_ok ? q_left : SENT;
        rx = lr_ok ? $signed(NUM_W'(wq)) : SENT;
        ry = lr_ok ? q_right : SENT;
        tx = tb_ok ? q_top : SENT;
        ty = tb_ok ? '0 : SENT;
        bx = tb_ok ? q_bottom : SENT;
        by = tb_ok ? $signed(NUM_W'(hq)) : SENT;

        if (fl.ex_zero) begin
            // Vertical line: top to bottom.
            sx = tx;  sy = ty;  ex_o = bx;  ey_o = by;
        end else if (fl.dy_zero) begin
            // Horizontal line: left to right.
            sx = lx;  sy = ly;  ex_o = rx;  ey_o = ry;
        end else if (fl.same_sign) begin
            if (bx <= lx) begin
                sx = lx;  sy = ly;
            end else begin
                sx = bx;  sy = by;
            end
            if (tx <= rx) begin
                ex_o = tx;  ey_o = ty;
            end else begin
                ex_o = rx;  ey_o = ry;
            end
        end else begin
            if (tx <= lx) begin
                sx = lx;  sy = ly;
            end else begin
                sx = tx;  sy = ty;
            end
            if (bx <= rx) begin
                ex_o = bx;  ey_o = by;
            end else begin
                ex_o = rx;  ey_o = ry;
            end
        end
    end

    logic [lrc_pkg::TDATA_W-1:0] m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= vline_reg[DIV_LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= {(lrc_pkg::TDATA_W - 4 * FW)'(0),
                            sat_field(ey_o), sat_field(ex_o),
                            sat_field(sy), sat_field(sx)};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- dv/line_rectangle_clip_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_rectangle_clip_core_test
// Self-checking bench for the line to rectangle clipper. Each request is
// predicted at acceptance and the crossings are compared with every result,
// over several image sizes and with random idling on both streams.
// ----------------------------------------------------------------------------

// Holds the endpoints predicted for requests not yet answered.
class clip_scoreboard;
    logic [lrc_pkg::REG_W-1:0] width_px;
    logic [lrc_pkg::REG_W-1:0] height_px;
    logic [lrc_pkg::TDATA_W-1:0] endpoints_due[$];
    int errors;

    function new();
        width_px  = lrc_pkg::WIDTH_RESET;
        height_px = lrc_pkg::HEIGHT_RESET;
        errors    = 0;
    endfunction

    static function logic [18:0] clamp19(longint v);
        if (v > 262143) return 19'sd262143;
        if (v < -262144) return -19'sd262144;
        return v[18:0];
    endfunction

    // Works out the clipped endpoints of one request with the current image size.
    function void note_request(logic [lrc_pkg::TDATA_W-1:0] req);
        longint ax, ay, bx, by, dy, ex, c, wq, hq, sent;
        longint lx, ly, rx, ry, tx, ty, btx, bty, sx, sy, ox, oy;
        ax = longint'($signed(req[18:0]));
        ay = longint'($signed(req[37:19]));
        bx = longint'($signed(req[56:38]));
        by = longint'($signed(req[75:57]));
        dy = by - ay;
        ex = ax - bx;
        c  = dy * ax + ex * ay;
        wq = longint'(width_px) << lrc_pkg::FRAC_BITS_DEF;
        hq = longint'(height_px) << lrc_pkg::FRAC_BITS_DEF;
        sent = -(longint'(1) << lrc_pkg::FRAC_BITS_DEF);
        if (ex != 0 && height_px != 0) begin
            lx = 0;  ly = c / ex;
            rx = wq; ry = (c - dy * wq) / ex;
        end else begin
            lx = sent; ly = sent; rx = sent; ry = sent;
        end
        if (dy != 0 && width_px != 0) begin
            tx = c / dy;              ty = 0;
            btx = (c - ex * hq) / dy; bty = hq;
        end else begin
            tx = sent; ty = sent; btx = sent; bty = sent;
        end
        if (ex == 0) begin
            sx = tx; sy = ty; ox = btx; oy = bty;
        end else if (dy == 0) begin
            sx = lx; sy = ly; ox = rx; oy = ry;
        end else if ((dy > 0) == (ex > 0)) begin
            if (btx <= lx) begin sx = lx; sy = ly; end else begin sx = btx; sy = bty; end
            if (tx <= rx) begin ox = tx; oy = ty; end else begin ox = rx; oy = ry; end
        end else begin
            if (tx <= lx) begin sx = lx; sy = ly; end else begin sx = tx; sy = ty; end
            if (btx <= rx) begin ox = btx; oy = bty; end else begin ox = rx; oy = ry; end
        end
        endpoints_due.push_back({4'b0, clamp19(oy), clamp19(ox), clamp19(sy), clamp19(sx)});
    endfunction

    function void check_result(logic [lrc_pkg::TDATA_W-1:0] got);
        logic [lrc_pkg::TDATA_W-1:0] want;
        string names[4];
        names = '{"start_x", "start_y", "end_x", "end_y"};
        if (endpoints_due.size() == 0) begin
            $error("result %h arrived with no request outstanding", got);
            errors++;
            return;
        end
        want = endpoints_due.pop_front();
        for (int f = 0; f < 4; f++) begin
            if (want[f*19 +: 19] !== got[f*19 +: 19]) begin
                $error("%s: expected %0d, got %0d", names[f],
                       $signed(want[f*19 +: 19]), $signed(got[f*19 +: 19]));
                errors++;
            end
        end
    endfunction
endclass

module line_rectangle_clip_core_test;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 60;   // settling time after the last result

    logic                        aclk;
    logic                        aresetn;
    logic                        cfg_we;
    logic                        cfg_index;
    logic [lrc_pkg::REG_W-1:0]   cfg_wdata;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [lrc_pkg::TDATA_W-1:0] s_tdata;
    logic                        m_tvalid;
    logic                        m_tready;
    logic [lrc_pkg::TDATA_W-1:0] m_tdata;

    clip_scoreboard board;
    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;

    line_rectangle_clip_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // The receiver stalls at random according to the current phase.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Both handshakes are sampled here, before any register of the block
    // moves in this time step, so the values seen are those of the edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                board.note_request(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                board.check_result(m_tdata);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Nothing has moved on either stream for far too long: the block is stuck.
    always @(posedge aclk) begin
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("line_rectangle_clip_core_test NOT OK");
            $finish;
        end
    end

    // The enable drops before the task returns, so two writes in a row never
    // touch cfg_we twice in one time step.
    task automatic write_register(input lrc_pkg::reg_index_t idx,
                                  input logic [lrc_pkg::REG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        if (idx == lrc_pkg::REG_IMAGE_WIDTH) begin
            board.width_px = value;
        end else begin
            board.height_px = value;
        end
        @(posedge aclk);
    endtask

    // Offers one request and returns at the edge where it is taken. The valid
    // is left high when the task returns; drain or an idle gap lowers it.
    task automatic send_request(input logic [18:0] ax, input logic [18:0] ay,
                                input logic [18:0] bx, input logic [18:0] by);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do begin
                @(posedge aclk);
            end while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, by, bx, ay, ax};
        do begin
            @(posedge aclk);
        end while (!(s_tvalid && s_tready));
    endtask

    // Waits until every result has come back, then lets the pipeline settle.
    task automatic drain;
        s_tvalid <= 1'b0;
        while (board.endpoints_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // A coordinate somewhere around the image, with a random fraction.
    function automatic logic [18:0] near_image(input int extent);
        int whole;
        whole = $urandom_range(extent + 40) - 20;
        return 19'(whole * 16 + $urandom_range(15));
    endfunction

    task automatic random_requests(input int count);
        logic [18:0] ax, ay, bx, by;
        int kind;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(99);
            ax = near_image(board.width_px);
            ay = near_image(board.height_px);
            bx = near_image(board.width_px);
            by = near_image(board.height_px);
            if (kind < 15) begin
                // Anything the fields allow.
                ax = 19'($urandom); ay = 19'($urandom);
                bx = 19'($urandom); by = 19'($urandom);
            end else if (kind < 22) begin
                bx = ax;   // vertical
            end else if (kind < 29) begin
                by = ay;   // horizontal
            end else if (kind < 32) begin
                bx = ax;   // both points the same
                by = ay;
            end
            send_request(ax, ay, bx, by);
        end
    endtask

    initial begin
        logic [18:0] hi, lo;
        hi = 19'sd262143;
        lo = -19'sd262144;
        board          = new();
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = lrc_pkg::REG_IMAGE_WIDTH;
        cfg_wdata      = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        quiet_cycles   = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed requests with the reset image size of 640 by 480.
        send_request(19'd0, 19'd0, 19'd0, 19'd0);              // coincident at origin
        send_request(19'd1600, 19'd1600, 19'd1600, 19'd1600);  // coincident inside
        send_request(19'd160, 19'd0, 19'd160, 19'd320);        // vertical
        send_request(19'd160, 19'd320, 19'd160, 19'd0);        // vertical, upwards
        send_request(19'd0, 19'd160, 19'd320, 19'd160);        // horizontal
        send_request(19'd320, 19'd160, 19'd0, 19'd160);        // horizontal, leftwards
        send_request(19'd0, 19'd0, 19'd160, 19'd160);          // diagonal down-right
        send_request(19'd160, 19'd160, 19'd0, 19'd0);          // same line reversed
        send_request(19'd0, 19'd7680, 19'd160, 19'd7520);      // diagonal up-right
        send_request(19'd17, 19'd33, 19'd1234, 19'd5001);      // steep, fractions
        send_request(19'd10, 19'd3000, 19'd9000, 19'd3100);    // shallow
        send_request(lo, lo, hi, hi);                          // full-range diagonal
        send_request(hi, lo, lo, hi);                          // full-range anti-diagonal
        send_request(lo, hi, lo, lo);                          // vertical at the minimum
        send_request(lo, hi, hi, hi);                          // horizontal at the maximum
        send_request(hi, hi, hi, hi);                          // coincident at the maximum
        send_request(lo, lo, lo + 19'd1, hi);                  // nearly vertical, saturating
        send_request(lo, lo, hi, lo + 19'd1);                  // nearly horizontal
        send_request(19'h7FFFF, 19'h2AAAA, 19'h55555, 19'h00001); // alternating bits
        drain();

        // Random phases through several image sizes and idling patterns.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    write_register(lrc_pkg::REG_IMAGE_WIDTH, 13'd1);
                    write_register(lrc_pkg::REG_IMAGE_HEIGHT, 13'd1);
                end
                1: begin
                    write_register(lrc_pkg::REG_IMAGE_WIDTH, 13'd8191);
                    write_register(lrc_pkg::REG_IMAGE_HEIGHT, 13'd8191);
                end
                2: begin
                    write_register(lrc_pkg::REG_IMAGE_WIDTH, 13'd1);
                    write_register(lrc_pkg::REG_IMAGE_HEIGHT, 13'd8191);
                end
                3: begin
                    write_register(lrc_pkg::REG_IMAGE_WIDTH, 13'd640);
                    write_register(lrc_pkg::REG_IMAGE_HEIGHT, 13'd480);
                end
                default: begin
                    write_register(lrc_pkg::REG_IMAGE_WIDTH,
                                   13'($urandom_range(8191, 1)));
                    write_register(lrc_pkg::REG_IMAGE_HEIGHT,
                                   13'($urandom_range(8191, 1)));
                end
            endcase
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            random_requests(150);
            drain();
        end

        if (board.errors == 0 && board.endpoints_due.size() == 0) begin
            $display("line_rectangle_clip_core_test OK");
        end else begin
            $display("line_rectangle_clip_core_test NOT OK");
        end
        $finish;
    end
endmodule

// ----- files.f -----
rtl/lrc_pkg.sv
rtl/lrc_divider.sv
rtl/line_rectangle_clip_core.sv
dv/line_rectangle_clip_core_test.sv
